### src/fftms_pkg.sv
// Package for the FFT magnitude spectrum core: sizes, twiddle ROM, states.
// No dependencies.
`default_nettype none
package fftms_pkg;
    localparam int POINTS = 64;
    localparam int LG = $clog2(POINTS);
    localparam int ROM_BASE = 64;
    localparam logic [6:0] OUT_BINS_RESET = 7'd32;
    localparam logic [16:0] AMP_MAX = 17'd65536;

    typedef enum logic [3:0] {
        ST_LOAD, ST_BF_RD, ST_BF_MUL, ST_BF_SUM, ST_BF_WR,
        ST_OUT_RD, ST_OUT_SQ, ST_OUT_SUM, ST_SQRT, ST_OUT_HOLD
    } state_t;

    function automatic logic signed [17:0] quarter_rom(input logic [4:0] k);
        logic signed [17:0] v;
        unique case (k)
            5'd0: v = 18'sd32768;  5'd1: v = 18'sd32610;  5'd2: v = 18'sd32138;
            5'd3: v = 18'sd31357;  5'd4: v = 18'sd30274;  5'd5: v = 18'sd28899;
            5'd6: v = 18'sd27246;  5'd7: v = 18'sd25330;  5'd8: v = 18'sd23170;
            5'd9: v = 18'sd20788;  5'd10: v = 18'sd18205; 5'd11: v = 18'sd15447;
            5'd12: v = 18'sd12540; 5'd13: v = 18'sd9512;  5'd14: v = 18'sd6393;
            5'd15: v = 18'sd3212;  default: v = 18'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [17:0] rom_cos(input logic [4:0] k);
        logic signed [17:0] v;
        if (k <= 5'd16) v = quarter_rom(k);
        else v = -quarter_rom(5'(6'd32 - {1'b0, k}));
        return v;
    endfunction

    function automatic logic signed [17:0] rom_sin(input logic [4:0] k);
        logic signed [17:0] v;
        if (k <= 5'd16) v = quarter_rom(5'd16 - k);
        else v = quarter_rom(k - 5'd16);
        return v;
    endfunction
endpackage
`default_nettype wire

### src/fft_magnitude_spectrum_core.sv
// Top level of the FFT magnitude spectrum core: load, butterfly sequencer, output.
// Depends on fftms_pkg and fftms_sqrt.
//
// Usage: s_tvalid/s_tready/s_tdata carry one signed 16-bit sample per beat.
// Samples go to bit-reversed slots of a complex store, one per cycle.
// After the 64th sample the block drops s_tready and runs the FFT with one
// shared butterfly in four steps (read, multiply, sum, write), 192 butterflies.
// Then each bin is read, squared and summed, its root taken by an iterative
// square root and offered until the receiver takes it; the next bin is not
// read before then.
// Bins leave on m_tvalid/m_tready/m_tdata with m_tlast on the final bin.
// A stalled receiver holds the current beat; the sequencer waits on it.
// cfg_valid/cfg_ready write out_bins (7 bits); always ready.
// Reset clears the sample count and sets out_bins to 32; the stores are
// not cleared since every entry is written before it is read.
`default_nettype none
module fft_magnitude_spectrum_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // [15:0] sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,     // [5:0] bin_index, [22:6] amplitude, [23] pad
    output logic             m_tlast,     // last_bin
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data     // out_bins
);
    import fftms_pkg::*;

    logic signed [31:0] re_mem [POINTS];
    logic signed [31:0] im_mem [POINTS];

    state_t state_reg, state_next;
    logic [LG-1:0] cnt_reg, cnt_next;
    logic [6:0] out_bins_reg;
    logic [6:0] nb_reg, nb_next;
    logic [LG-1:0] stg_reg, stg_next;      // stage
    logic [LG-1:0] bf_reg, bf_next;        // butterfly in stage
    logic [LG-1:0] bin_reg, bin_next;

    logic signed [31:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [17:0] c_reg, sn_reg;
    logic signed [49:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [31:0] tr_reg, ti_reg;
    logic [63:0] sum_sq;
    logic [16:0] amp_reg;

    logic [LG-1:0] slot, h, k, a_idx, b_idx;
    logic [4:0] tw;
    logic signed [50:0] sr, si;
    logic sq_start, sq_done;
    logic [31:0] sq_root;
    logic [32:0] q;

    always_comb
    begin
        for (int i = 0; i < LG; i++)
            slot[i] = cnt_reg[LG-1-i];
    end

    // Butterfly addressing: h = 2^stage, k = bf mod h
    assign h = LG'(1) << stg_reg;
    assign k = bf_reg & (h - LG'(1));
    assign a_idx = ((bf_reg & ~(h - LG'(1))) << 1) | k;
    assign b_idx = a_idx | h;
    assign tw = 5'(({1'b0, k} * (7'(ROM_BASE) >> (stg_reg + 1'b1))));

    assign sr = 51'(p0_reg) + 51'(p1_reg) + 51'sd16384;
    assign si = 51'(p2_reg) - 51'(p3_reg) + 51'sd16384;

    // 16 * (re^2 + im^2), taken by the root unit at the end of ST_OUT_SUM
    assign sum_sq = (64'(unsigned'(p0_reg)) + 64'(unsigned'(p1_reg))) << 4;

    assign s_tready = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign sq_start = (state_reg == ST_OUT_SUM);

    fftms_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sum_sq),
        .done(sq_done), .root(sq_root)
    );

    assign q = ({1'b0, sq_root} + 33'(POINTS)) >> (LG + 1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        nb_next = nb_reg;
        stg_next = stg_reg;
        bf_next = bf_reg;
        bin_next = bin_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LG'(POINTS - 1))
                    begin
                        state_next = ST_BF_RD;
                        stg_next = '0;
                        bf_next = '0;
                        if (out_bins_reg == 7'd0) nb_next = 7'd1;
                        else if (out_bins_reg > 7'(POINTS)) nb_next = 7'(POINTS);
                        else nb_next = out_bins_reg;
                    end
                end
            end
            ST_BF_RD:  state_next = ST_BF_MUL;
            ST_BF_MUL: state_next = ST_BF_SUM;
            ST_BF_SUM: state_next = ST_BF_WR;
            ST_BF_WR:
            begin
                state_next = ST_BF_RD;
                bf_next = bf_reg + 1'b1;
                if (bf_reg == LG'(POINTS / 2 - 1))
                begin
                    bf_next = '0;
                    stg_next = stg_reg + 1'b1;
                    if (stg_reg == LG'(LG - 1))
                    begin
                        state_next = ST_OUT_RD;
                        bin_next = '0;
                    end
                end
            end
            ST_OUT_RD:  state_next = ST_OUT_SQ;
            ST_OUT_SQ:  state_next = ST_OUT_SUM;
            ST_OUT_SUM: state_next = ST_SQRT;
            ST_SQRT:    if (sq_done) state_next = ST_OUT_HOLD;
            ST_OUT_HOLD:
            begin
                if (m_tready)
                begin
                    bin_next = bin_reg + 1'b1;
                    if (7'(bin_reg) + 7'd1 == nb_reg) state_next = ST_LOAD;
                    else state_next = ST_OUT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign m_tvalid = (state_reg == ST_OUT_HOLD);
    assign m_tlast = (7'(bin_reg) + 7'd1 == nb_reg);
    assign m_tdata = {1'b0, amp_reg, 6'(bin_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg <= '0;
            out_bins_reg <= OUT_BINS_RESET;
            nb_reg <= 7'd1;
            stg_reg <= '0;
            bf_reg <= '0;
            bin_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            nb_reg <= nb_next;
            stg_reg <= stg_next;
            bf_reg <= bf_next;
            bin_reg <= bin_next;
            if (cfg_valid) out_bins_reg <= cfg_data;
        end
    end

    // Datapath and store
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid)
                begin
                    re_mem[slot] <= 32'(signed'(s_tdata));
                    im_mem[slot] <= 32'sd0;
                end
            end
            ST_BF_RD:
            begin
                ar_reg <= re_mem[a_idx];
                ai_reg <= im_mem[a_idx];
                br_reg <= re_mem[b_idx];
                bi_reg <= im_mem[b_idx];
                c_reg <= rom_cos(tw);
                sn_reg <= rom_sin(tw);
            end
            ST_BF_MUL:
            begin
                p0_reg <= 50'(br_reg) * 50'(c_reg);
                p1_reg <= 50'(bi_reg) * 50'(sn_reg);
                p2_reg <= 50'(bi_reg) * 50'(c_reg);
                p3_reg <= 50'(br_reg) * 50'(sn_reg);
            end
            ST_BF_SUM:
            begin
                tr_reg <= 32'(sr >>> 15);
                ti_reg <= 32'(si >>> 15);
            end
            ST_BF_WR:
            begin
                re_mem[a_idx] <= ar_reg + tr_reg;
                im_mem[a_idx] <= ai_reg + ti_reg;
                re_mem[b_idx] <= ar_reg - tr_reg;
                im_mem[b_idx] <= ai_reg - ti_reg;
            end
            ST_OUT_RD:
            begin
                ar_reg <= re_mem[bin_reg];
                ai_reg <= im_mem[bin_reg];
            end
            ST_OUT_SQ:
            begin
                p0_reg <= 50'(ar_reg) * 50'(ar_reg);
                p1_reg <= 50'(ai_reg) * 50'(ai_reg);
            end
            ST_SQRT:
                amp_reg <= (q > 33'(AMP_MAX)) ? AMP_MAX : q[16:0];
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### src/fftms_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// No dependencies.
`default_nettype none
module fftms_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);
    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;
    assign root = r_reg[31:0];
    assign done = busy_reg && (bit_reg == 64'd0);

    always_comb
    begin
        v_next = v_reg;
        r_next = r_reg;
        bit_next = bit_reg;
        busy_next = busy_reg;
        if (start)
        begin
            v_next = radicand;
            r_next = 64'd0;
            bit_next = 64'd1 << 62;
            busy_next = 1'b1;
        end
        else if (busy_reg && bit_reg != 64'd0)
        begin
            if (v_reg >= trial)
            begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
        bit_reg <= bit_next;
    end
endmodule
`default_nettype wire
